>>> hdl/won_pkg.sv
`default_nettype none
package won_pkg;

  localparam logic [31:0] K_HASH_X = 32'd738295859;
  localparam logic [31:0] K_HASH_Y = 32'd1103515245;
  localparam logic [31:0] K_HASH_SEED = 32'd2654435761;
  localparam logic [31:0] K_HASH_MIX = 32'd2246822519;
  localparam logic [16:0] ONE_Q16 = 17'd65536;
  localparam int SUM_W = 37;
  localparam int TOT_W = 21;

  localparam logic [2:0] REG_OFFSET_X = 3'd0;
  localparam logic [2:0] REG_OFFSET_Y = 3'd1;
  localparam logic [2:0] REG_X_SCALE = 3'd2;
  localparam logic [2:0] REG_Y_SCALE = 3'd3;
  localparam logic [2:0] REG_OCTAVES = 3'd4;
  localparam logic [2:0] REG_LACUNARITY = 3'd5;
  localparam logic [2:0] REG_GAIN = 3'd6;
  localparam logic [2:0] REG_SEED = 3'd7;

  typedef struct packed {
    logic              valid;
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    logic [31:0]        freq;
    logic [16:0]        amp;
    logic [SUM_W-1:0]   sum;
    logic [TOT_W-1:0]   total;
  } oct_t;

  // Floor of a signed product over 2^sh, saturated to the signed 32-bit range.
  function automatic logic signed [31:0] mfloor(input logic neg, input logic [65:0] p,
                                                input int sh);
    logic [65:0] q;
    logic        rb;
    q = p >> sh;
    rb = (p & ((66'd1 << sh) - 66'd1)) != 66'd0;
    if (!neg) begin
      if (q > 66'h7FFF_FFFF) mfloor = 32'h7FFF_FFFF;
      else mfloor = q[31:0];
    end else begin
      q = q + 66'(rb);
      if (q > 66'h8000_0000) mfloor = 32'h8000_0000;
      else mfloor = 32'(66'd0 - q);
    end
  endfunction

endpackage
`default_nettype wire

>>> hdl/won_front.sv
`default_nettype none
module won_front #(
  parameter int FRACTION_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire logic               in_valid,
  input  wire logic signed [31:0] pos_x,
  input  wire logic signed [31:0] pos_y,
  input  wire logic signed [31:0] offset_x,
  input  wire logic signed [31:0] offset_y,
  input  wire logic [31:0]        x_scale,
  input  wire logic [31:0]        y_scale,
  output won_pkg::oct_t           o
);
  import won_pkg::*;

  logic               v1, v2, v3;
  logic signed [32:0] sx, sy;
  logic               negx, negy;
  logic [64:0]        px, py;
  logic signed [31:0] nx, ny;
  logic [32:0]        mx, my;

  always_comb begin
    mx = sx[32] ? 33'(-sx) : 33'(sx);
    my = sy[32] ? 33'(-sy) : 33'(sy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sx <= 33'(pos_x) + 33'(offset_x);
      sy <= 33'(pos_y) + 33'(offset_y);
      negx <= sx[32];
      negy <= sy[32];
      px <= mx * x_scale;
      py <= my * y_scale;
      nx <= mfloor(negx, {1'b0, px}, 32 - FRACTION_BITS);
      ny <= mfloor(negy, {1'b0, py}, 32 - FRACTION_BITS);
    end
  end

  always_comb begin
    o.valid = v3;
    o.nx = nx;
    o.ny = ny;
    o.freq = 32'd65536;
    o.amp = ONE_Q16;
    o.sum = '0;
    o.total = '0;
  end
endmodule
`default_nettype wire

>>> hdl/won_octave.sv
`default_nettype none
module won_octave #(
  parameter int OCT = 0,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  wire logic        active,
  input  wire logic [15:0] lacunarity,
  input  wire logic [15:0] gain,
  input  wire logic [31:0] seed,
  input  won_pkg::oct_t    i,
  output won_pkg::oct_t    o
);
  import won_pkg::*;

  localparam int NST = 14;

  oct_t               pipe [1:NST];
  logic [31:0]        seedk;
  logic [31:0]        mgx, mgy;
  logic               negx, negy;
  logic [63:0]        px, py;
  logic signed [31:0] x, y;
  logic [31:0]        hxa, hya;
  logic [15:0]        fx, fy, fxc, fyc;
  logic [15:0]        fxd1, fyd1, fxd2, fyd2;
  logic [31:0]        ax [3];
  logic [31:0]        ay [3];
  logic [31:0]        h1 [9];
  logic [31:0]        h2 [9];
  logic [31:0]        h3 [9];
  logic signed [18:0] ox [9];
  logic signed [18:0] oy [9];
  logic signed [37:0] tx [9];
  logic signed [37:0] ty [9];
  logic [34:0]        sq [9];
  logic [34:0]        m3 [3];
  logic [34:0]        nearest;
  logic               big [4:0];
  logic [19:0]        rem [4:0];
  logic [15:0]        root [4:0];
  logic [31:0]        vb [4:0];
  logic [16:0]        dmin;
  logic [33:0]        prod;
  logic [47:0]        fp;
  logic [32:0]        ap;
  logic signed [18:0] doff [3];
  oct_t               outr;

  assign doff[0] = -19'sd65536;
  assign doff[1] = 19'sd0;
  assign doff[2] = 19'sd65536;

  always_ff @(posedge clk) begin
    seedk <= (seed + 32'(OCT)) * K_HASH_SEED;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= NST; k++) pipe[k].valid <= 1'b0;
    end else if (en) begin
      pipe[1].valid <= i.valid;
      for (int k = 2; k <= NST; k++) pipe[k].valid <= pipe[k-1].valid;
    end
    if (en) begin
      pipe[1].nx <= i.nx;
      pipe[1].ny <= i.ny;
      pipe[1].freq <= i.freq;
      pipe[1].amp <= i.amp;
      pipe[1].sum <= i.sum;
      pipe[1].total <= i.total;
      for (int k = 2; k <= NST; k++) begin
        pipe[k].nx <= pipe[k-1].nx;
        pipe[k].ny <= pipe[k-1].ny;
        pipe[k].freq <= pipe[k-1].freq;
        pipe[k].amp <= pipe[k-1].amp;
        pipe[k].sum <= pipe[k-1].sum;
        pipe[k].total <= pipe[k-1].total;
      end
    end
  end

  always_comb begin
    mgx = i.nx[31] ? 32'(-i.nx) : 32'(i.nx);
    mgy = i.ny[31] ? 32'(-i.ny) : 32'(i.ny);
  end

  generate
    if (FRACTION_BITS >= 16) begin : g_frac_hi
      assign fxc = x[FRACTION_BITS-1 -: 16];
      assign fyc = y[FRACTION_BITS-1 -: 16];
    end else begin : g_frac_lo
      assign fxc = {x[FRACTION_BITS-1:0], (16 - FRACTION_BITS)'(0)};
      assign fyc = {y[FRACTION_BITS-1:0], (16 - FRACTION_BITS)'(0)};
    end
  endgenerate

  always_comb begin
    ax[0] = hxa - K_HASH_X;
    ax[1] = hxa;
    ax[2] = hxa + K_HASH_X;
    ay[0] = hya - K_HASH_Y;
    ay[1] = hya;
    ay[2] = hya + K_HASH_Y;
    for (int k = 0; k < 9; k++) begin
      h3[k] = h2[k] ^ (h2[k] >> 13);
      tx[k] = ox[k] * ox[k];
      ty[k] = oy[k] * oy[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      negx <= i.nx[31];
      negy <= i.ny[31];
      px <= mgx * i.freq;
      py <= mgy * i.freq;
      x <= mfloor(negx, {2'b0, px}, 16);
      y <= mfloor(negy, {2'b0, py}, 16);
      hxa <= 32'(x >>> FRACTION_BITS) * K_HASH_X;
      hya <= 32'(y >>> FRACTION_BITS) * K_HASH_Y;
      fx <= fxc;
      fy <= fyc;
      fxd1 <= fx;
      fyd1 <= fy;
      fxd2 <= fxd1;
      fyd2 <= fyd1;
      for (int a = 0; a < 3; a++) begin
        for (int b = 0; b < 3; b++) begin
          h1[a*3+b] <= (ax[a] ^ ay[b] ^ seedk) ^ ((ax[a] ^ ay[b] ^ seedk) >> 15);
          ox[a*3+b] <= doff[a] + $signed({3'b0, h3[a*3+b][15:0]}) - $signed({3'b0, fxd2});
          oy[a*3+b] <= doff[b] + $signed({3'b0, h3[a*3+b][31:16]}) - $signed({3'b0, fyd2});
        end
      end
      for (int k = 0; k < 9; k++) begin
        h2[k] <= h1[k] * K_HASH_MIX;
        sq[k] <= 35'(tx[k]) + 35'(ty[k]);
      end
      for (int g = 0; g < 3; g++) begin
        m3[g] <= (sq[3*g] < sq[3*g+1])
                 ? ((sq[3*g] < sq[3*g+2]) ? sq[3*g] : sq[3*g+2])
                 : ((sq[3*g+1] < sq[3*g+2]) ? sq[3*g+1] : sq[3*g+2]);
      end
      nearest <= (m3[0] < m3[1]) ? ((m3[0] < m3[2]) ? m3[0] : m3[2])
                                 : ((m3[1] < m3[2]) ? m3[1] : m3[2]);
    end
  end

  assign big[0] = nearest[34:32] != 3'd0;
  assign rem[0] = '0;
  assign root[0] = '0;
  assign vb[0] = nearest[31:0];

  genvar s;
  generate
    for (s = 0; s < 4; s++) begin : g_sqrt
      logic [19:0] r_c;
      logic [15:0] q_c;
      logic [31:0] v_c;
      always_comb begin
        r_c = rem[s];
        q_c = root[s];
        v_c = vb[s];
        for (int j = 0; j < 4; j++) begin
          r_c = {r_c[17:0], v_c[31:30]};
          v_c = {v_c[29:0], 2'b00};
          if (r_c >= {2'b00, q_c, 2'b01}) begin
            r_c = r_c - {2'b00, q_c, 2'b01};
            q_c = {q_c[14:0], 1'b1};
          end else begin
            q_c = {q_c[14:0], 1'b0};
          end
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          rem[s+1] <= r_c;
          root[s+1] <= q_c;
          vb[s+1] <= v_c;
          big[s+1] <= big[s];
        end
      end
    end
  endgenerate

  assign dmin = big[4] ? ONE_Q16 : {1'b0, root[4]};

  always_ff @(posedge clk) begin
    if (rst) outr.valid <= 1'b0;
    else if (en) outr.valid <= pipe[NST].valid;
    if (en) begin
      prod <= active ? dmin * pipe[13].amp : 34'd0;
      fp <= pipe[13].freq * lacunarity;
      ap <= pipe[13].amp * gain;
      outr.nx <= pipe[NST].nx;
      outr.ny <= pipe[NST].ny;
      outr.freq <= (fp[47:44] != 4'd0) ? 32'hFFFF_FFFF : fp[43:12];
      outr.amp <= ap[32:16];
      outr.sum <= pipe[NST].sum + SUM_W'(prod);
      outr.total <= pipe[NST].total + (active ? TOT_W'(pipe[NST].amp) : TOT_W'(0));
    end
  end

  assign o = outr;
endmodule
`default_nettype wire

>>> hdl/won_divide.sv
`default_nettype none
module won_divide (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  won_pkg::oct_t    i,
  output logic             out_valid,
  output logic [16:0]      out_value
);
  import won_pkg::*;

  localparam int NS = 6;

  logic             val [0:NS];
  logic [SUM_W:0]   rem [0:NS];
  logic [16:0]      quo [0:NS];
  logic [TOT_W-1:0] tot [0:NS];

  assign val[0] = i.valid;
  assign rem[0] = {1'b0, i.sum};
  assign quo[0] = '0;
  assign tot[0] = i.total;

  genvar s;
  generate
    for (s = 0; s < NS; s++) begin : g_div
      logic [SUM_W:0] r_c;
      logic [16:0]    q_c;
      always_comb begin
        int b;
        logic [SUM_W:0] t;
        r_c = rem[s];
        q_c = quo[s];
        for (int j = 0; j < 3; j++) begin
          b = 16 - 3 * s - j;
          if (b >= 0) begin
            t = (SUM_W+1)'(tot[s]) << b;
            if (r_c >= t) begin
              r_c = r_c - t;
              q_c[b] = 1'b1;
            end
          end
        end
      end
      always_ff @(posedge clk) begin
        if (rst) val[s+1] <= 1'b0;
        else if (en) val[s+1] <= val[s];
      end
      always_ff @(posedge clk) begin
        if (en) begin
          rem[s+1] <= r_c;
          quo[s+1] <= q_c;
          tot[s+1] <= tot[s];
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= val[NS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (tot[NS] == '0) out_value <= 17'd0;
      else if (quo[NS] > ONE_Q16) out_value <= ONE_Q16;
      else out_value <= quo[NS];
    end
  end
endmodule
`default_nettype wire

>>> hdl/worley_octave_noise.sv
// Stages from an accepted position to its result beat:
// 3 front stages, 15 stages per octave, 7 divider stages, 1 output buffer stage.
// Throughput: one position per cycle while the pipeline is not halted; every octave has its own pipeline section.
// The pipeline halts only when the two-entry output buffer is full.
// Synchronous reset clears all valid bits, empties the output buffer and resets the configuration registers.
`default_nettype none
module worley_octave_noise #(
  parameter int MAX_OCTAVES = 8,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               pos_valid,
  output logic                    pos_stall,
  input  wire logic signed [31:0] pos_x,
  input  wire logic signed [31:0] pos_y,
  output logic                    noise_valid,
  input  wire logic               noise_stall,
  output logic [16:0]             noise_value
);
  import won_pkg::*;

  logic signed [31:0] offset_x, offset_y;
  logic [31:0]        x_scale, y_scale, seed;
  logic [3:0]         octave_count;
  logic [15:0]        lacunarity, gain;
  logic [4:0]         oct_eff;
  logic               en;
  oct_t               chain [0:MAX_OCTAVES];
  logic               d_valid;
  logic [16:0]        d_value;
  logic [1:0]         cnt;
  logic [16:0]        buf_q [2];
  logic               push, pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x <= '0;
      offset_y <= '0;
      x_scale <= 32'd65536;
      y_scale <= 32'd65536;
      octave_count <= 4'd1;
      lacunarity <= 16'd8192;
      gain <= 16'd32768;
      seed <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OFFSET_X: offset_x <= cfg_data;
        REG_OFFSET_Y: offset_y <= cfg_data;
        REG_X_SCALE: x_scale <= cfg_data;
        REG_Y_SCALE: y_scale <= cfg_data;
        REG_OCTAVES: octave_count <= cfg_data[3:0];
        REG_LACUNARITY: lacunarity <= cfg_data[15:0];
        REG_GAIN: gain <= cfg_data[15:0];
        REG_SEED: seed <= cfg_data;
        default: ;
      endcase
    end
  end

  assign oct_eff = ({1'b0, octave_count} > 5'(MAX_OCTAVES)) ? 5'(MAX_OCTAVES)
                                                            : {1'b0, octave_count};
  assign en = cnt != 2'd2;
  assign pos_stall = !en;

  won_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
    .clk(clk), .rst(rst), .en(en), .in_valid(pos_valid && !pos_stall),
    .pos_x(pos_x), .pos_y(pos_y), .offset_x(offset_x), .offset_y(offset_y),
    .x_scale(x_scale), .y_scale(y_scale), .o(chain[0])
  );

  genvar g;
  generate
    for (g = 0; g < MAX_OCTAVES; g++) begin : g_oct
      won_octave #(.OCT(g), .FRACTION_BITS(FRACTION_BITS)) u_oct (
        .clk(clk), .rst(rst), .en(en), .active(5'(g) < oct_eff),
        .lacunarity(lacunarity), .gain(gain), .seed(seed),
        .i(chain[g]), .o(chain[g+1])
      );
    end
  endgenerate

  won_divide u_div (
    .clk(clk), .rst(rst), .en(en), .i(chain[MAX_OCTAVES]),
    .out_valid(d_valid), .out_value(d_value)
  );

  assign push = en && d_valid;
  assign pop = noise_valid && !noise_stall;

  always_ff @(posedge clk) begin
    if (rst) cnt <= 2'd0;
    else if (push && !pop) cnt <= cnt + 2'd1;
    else if (pop && !push) cnt <= cnt - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (push && !pop) buf_q[cnt[0]] <= d_value;
    else if (pop && !push) buf_q[0] <= buf_q[1];
    else if (push && pop) buf_q[0] <= d_value;
  end

  assign noise_valid = cnt != 2'd0;
  assign noise_value = buf_q[0];
endmodule
`default_nettype wire

>>> hdl/won_checker.sv
`default_nettype none
module won_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        pos_stall,
  input wire logic        noise_valid,
  input wire logic        noise_stall,
  input wire logic [16:0] noise_value
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !noise_valid)
    else $error("Result beat shown right after reset.");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    noise_valid && noise_stall |=> noise_valid && $stable(noise_value))
    else $error("Stalled result beat changed.");

  a_range: assert property (@(posedge clk) disable iff (rst)
    noise_valid |-> noise_value <= 17'd65536)
    else $error("Noise value above one.");

  a_no_needless_stall: assert property (@(posedge clk) disable iff (rst)
    !noise_valid |-> !pos_stall)
    else $error("Input stalled while the output buffer is empty.");

  a_stall_needs_backlog: assert property (@(posedge clk) disable iff (rst)
    pos_stall |-> $past(noise_valid && noise_stall))
    else $error("Input stalled without a held result beat.");

endmodule

bind worley_octave_noise won_checker u_won_checker (
  .clk(clk), .rst(rst), .pos_stall(pos_stall),
  .noise_valid(noise_valid), .noise_stall(noise_stall), .noise_value(noise_value)
);
`default_nettype wire
